@@ rtl/core/rgb_to_hsl_convert_top_defines.svh @@
// ----------------------------------------------------------------------------
// RGB to HSL converter assertion macros
// Shared property wrappers, clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERT_TOP_DEFINES_SVH
`define RGB_TO_HSL_CONVERT_TOP_DEFINES_SVH

// Same-cycle implication.
`define RHC_ASSERT_IMPLY(lbl, cond, conseq) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("rhc assertion failed");

// Next-cycle implication.
`define RHC_ASSERT_NEXT(lbl, cond, conseq) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("rhc assertion failed");

`endif

@@ rtl/core/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Field widths, hue angle constants and the sideband carried past the divider.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int CHAN_W = 8;
   localparam int SUM_W  = 9;
   localparam int HUE_W  = 15;
   localparam int SAT_W  = 16;
   localparam int NUM_W  = 24;
   localparam int DEN_W  = 8;
   localparam int QUO_W  = 16;
   localparam int IN_DATA_W  = 24;
   localparam int OUT_DATA_W = 40;

   // Hue angles in 1/64 degree units.
   localparam logic [HUE_W-1:0] HUE_120 = 15'd7680;
   localparam logic [HUE_W-1:0] HUE_240 = 15'd15360;
   localparam logic [HUE_W-1:0] HUE_360 = 15'd23040;
   localparam logic [11:0]      HUE_60  = 12'd3840;

   localparam logic [SUM_W-1:0] SUM_HALF = 9'd255;
   localparam logic [SUM_W-1:0] SUM_FULL = 9'd510;

   typedef enum logic [1:0] {
      MAX_RED,
      MAX_GREEN,
      MAX_BLUE
   } max_sel_type;

   typedef struct packed {
      max_sel_type      sel;
      logic             neg;
      logic             grey;
      logic [SUM_W-1:0] sum;
      logic             eof;
   } side_type;

endpackage

@@ rtl/core/rgb_to_hsl_convert_top.sv @@
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per beat to hue, saturation and lightness sum.
// ----------------------------------------------------------------------------
//  Channel  Ports     Beat contents
//  input    req_*     tdata: red, green, blue; tlast: end of frame
//  result   rsp_*     tdata: hue, saturation, lightness sum; tlast: frame done
//
// One pixel enters per clock while req_tready is high. Stage 1, stage 2, the divider stages
// and the result register follow in that order; the divider takes two quotient bits a stage by default.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline advances whenever the result register is empty or taken,
// so req_tready drops only while a held result waits on rsp_tready.
// ----------------------------------------------------------------------------
`include "rgb_to_hsl_convert_top_defines.svh"

module rgb_to_hsl_convert_top #(
   parameter int DIV_BITS_PER_STAGE = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rhc_pkg::IN_DATA_W-1:0]    req_tdata,  // red, green, blue
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rhc_pkg::OUT_DATA_W-1:0]   rsp_tdata,  // hue, saturation, lightness_sum
   output logic                             rsp_tlast
);
   import rhc_pkg::*;

   logic advance;

   // Stage 1: max, min and the channel difference for the hue.
   logic [CHAN_W-1:0] red, green, blue;
   max_sel_type       s1_sel_in;
   logic [CHAN_W-1:0] s1_max_in, s1_min_in, s1_a_in, s1_b_in;
   logic              s1_vld_ff;
   max_sel_type       s1_sel_ff;
   logic              s1_neg_ff;
   logic [CHAN_W-1:0] s1_mag_ff;
   logic [CHAN_W-1:0] s1_delta_ff;
   logic [SUM_W-1:0]  s1_sum_ff;
   logic              s1_eof_ff;

   // Stage 2: numerators and denominators for both divisions.
   logic              s2_vld_ff;
   logic [NUM_W-1:0]  s2_hue_num_ff, s2_sat_num_ff;
   logic [DEN_W-1:0]  s2_hue_den_ff, s2_sat_den_ff;
   side_type          s2_side_ff;
   logic [DEN_W-1:0]  s2_sat_den_in;

   logic              div_vld;
   logic [QUO_W-1:0]  div_hue_q, div_sat_q;
   side_type          div_side;

   logic [HUE_W-1:0]  hue_q;
   logic [HUE_W-1:0]  hue_in;
   logic [SAT_W-1:0]  sat_in;
   logic              rsp_tvalid_ff;
   logic [OUT_DATA_W-1:0] rsp_tdata_ff;
   logic              rsp_tlast_ff;

   assign advance    = ~rsp_tvalid_ff | rsp_tready;
   assign req_tready = advance;

   assign red   = req_tdata[7:0];
   assign green = req_tdata[15:8];
   assign blue  = req_tdata[23:16];

   always_comb begin
      if (red >= green && red >= blue) begin
         s1_sel_in = MAX_RED;
         s1_max_in = red;
         s1_a_in   = green;
         s1_b_in   = blue;
      end else if (green >= blue) begin
         s1_sel_in = MAX_GREEN;
         s1_max_in = green;
         s1_a_in   = blue;
         s1_b_in   = red;
      end else begin
         s1_sel_in = MAX_BLUE;
         s1_max_in = blue;
         s1_a_in   = red;
         s1_b_in   = green;
      end
      s1_min_in = red;
      if (green < s1_min_in) begin
         s1_min_in = green;
      end
      if (blue < s1_min_in) begin
         s1_min_in = blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_tvalid;
      end
      if (advance) begin
         s1_sel_ff   <= s1_sel_in;
         s1_neg_ff   <= s1_a_in < s1_b_in;
         s1_mag_ff   <= (s1_a_in < s1_b_in) ? s1_b_in - s1_a_in : s1_a_in - s1_b_in;
         s1_delta_ff <= s1_max_in - s1_min_in;
         s1_sum_ff   <= {1'b0, s1_max_in} + {1'b0, s1_min_in};
         s1_eof_ff   <= req_tlast;
      end
   end

   // Above half lightness the saturation is taken against 510 minus the sum.
   always_comb begin
      if (s1_sum_ff <= SUM_HALF) begin
         s2_sat_den_in = s1_sum_ff[DEN_W-1:0];
      end else begin
         s2_sat_den_in = DEN_W'(SUM_FULL - s1_sum_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (advance) begin
         s2_hue_num_ff   <= NUM_W'(HUE_60) * NUM_W'(s1_mag_ff);
         s2_sat_num_ff   <= {s1_delta_ff, 16'h0000} - NUM_W'(s1_delta_ff);
         s2_hue_den_ff   <= s1_delta_ff;
         s2_sat_den_ff   <= s2_sat_den_in;
         s2_side_ff.sel  <= s1_sel_ff;
         s2_side_ff.neg  <= s1_neg_ff;
         s2_side_ff.grey <= s1_delta_ff == '0;
         s2_side_ff.sum  <= s1_sum_ff;
         s2_side_ff.eof  <= s1_eof_ff;
      end
   end

   rhc_div #(
      .BITS_PER_STAGE (DIV_BITS_PER_STAGE)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_vld_ff),
      .in_num_a  (s2_hue_num_ff),
      .in_den_a  (s2_hue_den_ff),
      .in_num_b  (s2_sat_num_ff),
      .in_den_b  (s2_sat_den_ff),
      .in_side   (s2_side_ff),
      .out_valid (div_vld),
      .out_quo_a (div_hue_q),
      .out_quo_b (div_sat_q),
      .out_side  (div_side)
   );

   // The hue quotient never exceeds 3840 but for grey pixels, so 15 bits hold every hue used.
   assign hue_q = div_hue_q[HUE_W-1:0];

   always_comb begin
      case (div_side.sel)
         MAX_RED:   hue_in = div_side.neg ? HUE_360 - hue_q : hue_q;
         MAX_GREEN: hue_in = div_side.neg ? HUE_120 - hue_q : HUE_120 + hue_q;
         MAX_BLUE:  hue_in = div_side.neg ? HUE_240 - hue_q : HUE_240 + hue_q;
         default:   hue_in = '0;
      endcase
      sat_in = div_sat_q;
      if (div_side.grey) begin
         hue_in = '0;
         sat_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= div_vld;
      end
      if (advance) begin
         rsp_tdata_ff <= {div_side.sum, sat_in, hue_in};
         rsp_tlast_ff <= div_side.eof;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `RHC_ASSERT_IMPLY(a_ready_when_empty, !rsp_tvalid, req_tready)
   `RHC_ASSERT_IMPLY(a_hue_range, rsp_tvalid, rsp_tdata[14:0] <= HUE_360)
   `RHC_ASSERT_IMPLY(a_sat_not_grey, rsp_tvalid && rsp_tdata[30:15] != '0, rsp_tdata[39:31] != '0 && rsp_tdata[39:31] != SUM_FULL)
   `RHC_ASSERT_NEXT(a_hold_on_stall, rsp_tvalid && !rsp_tready, rsp_tvalid && !req_tready == !rsp_tready)

endmodule

@@ rtl/core/rhc_div.sv @@
// ----------------------------------------------------------------------------
// RGB to HSL converter divider pipeline
// Two restoring dividers side by side, BITS_PER_STAGE quotient bits per stage.
// ----------------------------------------------------------------------------
module rhc_div #(
   parameter int BITS_PER_STAGE = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [rhc_pkg::NUM_W-1:0]   in_num_a,
   input  logic [rhc_pkg::DEN_W-1:0]   in_den_a,
   input  logic [rhc_pkg::NUM_W-1:0]   in_num_b,
   input  logic [rhc_pkg::DEN_W-1:0]   in_den_b,
   input  rhc_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic [rhc_pkg::QUO_W-1:0]   out_quo_a,
   output logic [rhc_pkg::QUO_W-1:0]   out_quo_b,
   output rhc_pkg::side_type           out_side
);
   import rhc_pkg::*;

   localparam int STAGES = QUO_W / BITS_PER_STAGE;

   logic [STAGES-1:0] vld_ff;
   logic [NUM_W-1:0]  rem_ff  [STAGES][2];
   logic [QUO_W-1:0]  quo_ff  [STAGES][2];
   logic [DEN_W-1:0]  den_ff  [STAGES][2];
   side_type          side_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic             vld_src;
      side_type         side_src;
      logic [NUM_W-1:0] rem_src [2];
      logic [QUO_W-1:0] quo_src [2];
      logic [DEN_W-1:0] den_src [2];
      logic [NUM_W-1:0] rem_in  [2];
      logic [QUO_W-1:0] quo_in  [2];
      logic [NUM_W:0]   trial;

      if (s == 0) begin : g_first
         assign vld_src    = in_valid;
         assign side_src   = in_side;
         assign rem_src[0] = in_num_a;
         assign rem_src[1] = in_num_b;
         assign den_src[0] = in_den_a;
         assign den_src[1] = in_den_b;
         assign quo_src[0] = '0;
         assign quo_src[1] = '0;
      end else begin : g_next
         assign vld_src    = vld_ff[s-1];
         assign side_src   = side_ff[s-1];
         assign rem_src[0] = rem_ff[s-1][0];
         assign rem_src[1] = rem_ff[s-1][1];
         assign den_src[0] = den_ff[s-1][0];
         assign den_src[1] = den_ff[s-1][1];
         assign quo_src[0] = quo_ff[s-1][0];
         assign quo_src[1] = quo_ff[s-1][1];
      end

      // Each step tries the divisor at the next lower quotient weight.
      always_comb begin
         trial = '0;
         for (int l = 0; l < 2; l++) begin
            rem_in[l] = rem_src[l];
            quo_in[l] = quo_src[l];
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
               trial = {1'b0, rem_in[l]} -
                       ({1'b0, NUM_W'(den_src[l])} << (QUO_W - 1 - (s * BITS_PER_STAGE + k)));
               if (!trial[NUM_W]) begin
                  rem_in[l] = trial[NUM_W-1:0];
               end
               quo_in[l] = {quo_in[l][QUO_W-2:0], ~trial[NUM_W]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= vld_src;
         end
         if (advance) begin
            side_ff[s] <= side_src;
            for (int l = 0; l < 2; l++) begin
               rem_ff[s][l] <= rem_in[l];
               quo_ff[s][l] <= quo_in[l];
               den_ff[s][l] <= den_src[l];
            end
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_quo_a = quo_ff[STAGES-1][0];
   assign out_quo_b = quo_ff[STAGES-1][1];
   assign out_side  = side_ff[STAGES-1];

endmodule
